// ----- rtl/srfp_pkg.sv -----
// Shared types and constants of the sensor record frame packer.
// Used by the front, the frame queue, the back end and the top level.
package srfp_pkg;

    localparam int REC_W      = 120;   // laser, right, left, 24-bit time
    localparam int IMU_W      = 144;   // three 48-bit IMU parts
    localparam int TRL_W      = 24;    // sequence, block, transmit position
    localparam int RSV_W      = 16;    // bytes 123 and 124, always zero
    localparam int RECS       = 7;
    localparam int SLOT_W     = 3;
    localparam int WORDS      = 16;
    localparam int WIDX_W     = 4;
    localparam int WORD_W     = 64;
    localparam int FRAME_W    = 1024;
    localparam int BUFS       = 2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd6;
    localparam logic [WIDX_W-1:0] LAST_WORD = 4'hF;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Front to queue: one record slot write, and at frame end the IMU part,
    // the trailer and the push of the finished buffer.
    typedef struct packed {
        logic                 rec_we;
        logic [SLOT_W-1:0]    slot;
        logic [REC_W-1:0]     rec_data;
        logic                 push;
        logic [IMU_W-1:0]     imu_data;
        logic [TRL_W-1:0]     trailer;
    } t_wr_cmd;

    typedef struct packed {
        logic full;
    } t_q_stat;

    // Back end to queue.
    typedef struct packed {
        logic              pop;
        logic [WIDX_W-1:0] word_idx;
    } t_rd_req;

    // Queue to back end.
    typedef struct packed {
        logic              valid;
        logic [3:0]        block;
        logic [WORD_W-1:0] word;
    } t_rd_data;

endpackage

// ----- rtl/srfp_intf.sv -----
// Valid/ready channel interfaces of the sensor record frame packer.
// Depends on nothing; widths follow the record and frame word fields.
interface srfp_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] laser_bytes;
    logic [31:0] right_count;
    logic [31:0] left_count;
    logic [23:0] sample_time;
    logic [47:0] imu_part_a;
    logic [47:0] imu_part_b;
    logic [47:0] imu_part_c;
    logic [7:0]  transmit_position;

    modport source (
        output valid, kind, laser_bytes, right_count, left_count, sample_time,
               imu_part_a, imu_part_b, imu_part_c, transmit_position,
        input  ready
    );
    modport sink (
        input  valid, kind, laser_bytes, right_count, left_count, sample_time,
               imu_part_a, imu_part_b, imu_part_c, transmit_position,
        output ready
    );
endinterface

interface srfp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  block_number;
    logic [3:0]  word_index;
    logic [63:0] frame_word;
    logic        last_word;

    modport source (
        output valid, block_number, word_index, frame_word, last_word,
        input  ready
    );
    modport sink (
        input  valid, block_number, word_index, frame_word, last_word,
        output ready
    );
endinterface

// ----- rtl/sensor_record_frame_packer.sv -----
// Sensor record frame packer, top level. Records are taken one per cycle while
// a frame buffer is free; the seventh record of a frame pushes the buffer into
// the queue count register, then word 0 loads into the single output word
// register, and the 16 words follow one per cycle while the output is ready.
// Two frame buffers sit between front and back. Synchronous reset clears all
// control state; frame contents need no reset.
module sensor_record_frame_packer #(
    parameter int BLOCK_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srfp_in_if.sink     i_in,
    srfp_out_if.source  o_out
);
    srfp_pkg::t_wr_cmd  w_cmd;
    srfp_pkg::t_q_stat  w_stat;
    srfp_pkg::t_rd_req  w_req;
    srfp_pkg::t_rd_data w_rd;

    srfp_front #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    srfp_frame_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (w_req),
        .o_stat  (w_stat),
        .o_rd    (w_rd)
    );

    srfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_rd),
        .o_req   (w_req),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/srfp_front.sv -----
// Front end: accepts records and clear items, tracks the group position,
// frame sequence and block number, and writes records into the frame queue.
// Depends on srfp_pkg and srfp_in_if.
module srfp_front #(
    parameter int BLOCK_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    srfp_in_if.sink            i_in,
    input  srfp_pkg::t_q_stat  i_stat,
    output srfp_pkg::t_wr_cmd  o_cmd
);
    localparam int BLK_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_COUNT - 1);

    logic [srfp_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [BLK_W-1:0]            r_blk, n_blk;
    logic [7:0]                  r_seq, n_seq;
    logic                        w_acc;
    logic                        w_rec;
    logic                        w_done;
    logic [7:0]                  w_blk_byte;

    assign i_in.ready = !i_stat.full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_rec      = w_acc && (i_in.kind == srfp_pkg::KIND_RECORD);
    assign w_done     = w_rec && (r_slot == srfp_pkg::LAST_SLOT);

    always_comb begin
        w_blk_byte = '0;
        w_blk_byte[BLK_W-1:0] = r_blk;
    end

    always_comb begin
        n_slot = r_slot;
        n_blk  = r_blk;
        n_seq  = r_seq;
        if (w_acc && (i_in.kind == srfp_pkg::KIND_CLEAR)) begin
            // The sequence number survives a clear.
            n_slot = '0;
            n_blk  = '0;
        end else if (w_done) begin
            n_slot = '0;
            n_seq  = r_seq + 8'd1;
            n_blk  = (r_blk == BLK_LAST) ? '0 : r_blk + 1'b1;
        end else if (w_rec) begin
            n_slot = r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_blk  <= '0;
            r_seq  <= '0;
        end else begin
            r_slot <= n_slot;
            r_blk  <= n_blk;
            r_seq  <= n_seq;
        end
    end

    always_comb begin
        o_cmd.rec_we   = w_rec;
        o_cmd.slot     = r_slot;
        o_cmd.rec_data = {i_in.laser_bytes, i_in.right_count, i_in.left_count,
                          i_in.sample_time};
        o_cmd.push     = w_done;
        o_cmd.imu_data = {i_in.imu_part_a, i_in.imu_part_b, i_in.imu_part_c};
        o_cmd.trailer  = {r_seq, w_blk_byte, i_in.transmit_position};
    end

endmodule

// ----- rtl/srfp_frame_queue.sv -----
// Two-entry queue of frame buffers between the front and the back end.
// The front fills the write buffer in place; the back end reads finished ones.
// Depends on srfp_pkg.
module srfp_frame_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srfp_pkg::t_wr_cmd  i_cmd,
    input  srfp_pkg::t_rd_req  i_req,
    output srfp_pkg::t_q_stat  o_stat,
    output srfp_pkg::t_rd_data o_rd
);
    logic [srfp_pkg::REC_W-1:0] r_rec [srfp_pkg::BUFS][srfp_pkg::RECS];
    logic [srfp_pkg::IMU_W-1:0] r_imu [srfp_pkg::BUFS];
    logic [srfp_pkg::TRL_W-1:0] r_trl [srfp_pkg::BUFS];
    logic                       r_wr_ptr, r_rd_ptr;
    logic [1:0]                 r_count, n_count;

    logic [srfp_pkg::FRAME_W-1:0] w_frame;
    logic [srfp_pkg::WORD_W-1:0]  w_words [srfp_pkg::WORDS];

    // Payload storage, no reset: every frame rewrites all of its bytes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_we) begin
            r_rec[r_wr_ptr][i_cmd.slot] <= i_cmd.rec_data;
        end
        if (i_cmd.push) begin
            r_imu[r_wr_ptr] <= i_cmd.imu_data;
            r_trl[r_wr_ptr] <= i_cmd.trailer;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push && !i_req.pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_cmd.push && i_req.pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_req.pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Byte 0 of the frame sits in the top bits of the flat vector.
    always_comb begin
        w_frame = {r_rec[r_rd_ptr][0], r_rec[r_rd_ptr][1], r_rec[r_rd_ptr][2],
                   r_rec[r_rd_ptr][3], r_rec[r_rd_ptr][4], r_rec[r_rd_ptr][5],
                   r_rec[r_rd_ptr][6], r_imu[r_rd_ptr],
                   {srfp_pkg::RSV_W{1'b0}}, r_trl[r_rd_ptr]};
        for (int i = 0; i < srfp_pkg::WORDS; i++) begin
            w_words[i] = w_frame[srfp_pkg::FRAME_W - 1 - i * srfp_pkg::WORD_W -:
                                 srfp_pkg::WORD_W];
        end
    end

    assign o_stat.full = (r_count == 2'd2);
    assign o_rd.valid  = (r_count != 2'd0);
    assign o_rd.block  = r_trl[r_rd_ptr][11:8];
    assign o_rd.word   = w_words[i_req.word_idx];

endmodule

// ----- rtl/srfp_back.sv -----
// Back end: walks the head frame of the queue word by word into a
// registered output stage. Depends on srfp_pkg and srfp_out_if.
module srfp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srfp_pkg::t_rd_data i_rd,
    output srfp_pkg::t_rd_req  o_req,
    srfp_out_if.source         o_out
);
    logic [srfp_pkg::WIDX_W-1:0] r_idx;
    logic                        r_valid;
    logic [3:0]                  r_blk;
    logic [srfp_pkg::WIDX_W-1:0] r_out_idx;
    logic [srfp_pkg::WORD_W-1:0] r_word;
    logic                        r_last;
    logic                        w_load;
    logic                        w_is_last;

    assign w_load    = i_rd.valid && (!r_valid || o_out.ready);
    assign w_is_last = (r_idx == srfp_pkg::LAST_WORD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_blk     <= i_rd.block;
            r_out_idx <= r_idx;
            r_word    <= i_rd.word;
            r_last    <= w_is_last;
        end
    end

    // The buffer is released once its last word sits in the output stage.
    assign o_req.pop      = w_load && w_is_last;
    assign o_req.word_idx = r_idx;

    assign o_out.valid        = r_valid;
    assign o_out.block_number = r_blk;
    assign o_out.word_index   = r_out_idx;
    assign o_out.frame_word   = r_word;
    assign o_out.last_word    = r_last;

endmodule
